/* rtl/core/tsrt_pkg.sv */
// Package: types, codes and constants shared by the typed slot reservation table
`default_nettype none
package tsrt_pkg;

	localparam int SLOTS_DEF = 64;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ACTIVE_SLOTS = 1'b0;

	localparam logic [2:0] FUNC_INIT       = 3'd0;
	localparam logic [2:0] FUNC_RESERVE    = 3'd1;
	localparam logic [2:0] FUNC_FIND_OWNER = 3'd2;
	localparam logic [2:0] FUNC_FIND_ID    = 3'd3;
	localparam logic [2:0] FUNC_FIND_POS   = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic [5:0] slot_sel;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] kind;
		logic [7:0] client;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [5:0] slot;
		logic [7:0] out_x;
		logic [7:0] out_y;
		logic [7:0] out_kind;
	} rsp_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] kind;
		logic [7:0] owner;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic init_wr;
		logic zero_res;
		logic scan_start;
		logic capture;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_init;
		logic is_search;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/typed_slot_reservation_table_core.sv */
// Top level of the typed slot reservation table: request/response channels and config port
`default_nettype none
// One transaction at a time. Init and unknown function codes go to result delivery without
// a scan. Reserve and the find-by-owner and find-by-position lookups walk the slot memory
// through its single registered read port, one slot per cycle, over the first
// n = min(active_slots, SLOTS) slots, and stop at the first match. Find by id reads only the
// selected slot, and reads nothing when it lies outside the active range. The next request
// can be accepted in the cycle after the response is loaded; a response still held in the
// output register delays that load until it is taken, and the next request is accepted
// while the loaded response waits. active_slots is to be written only while the block is
// idle; the block itself does not enforce this.
module typed_slot_reservation_table_core
	import tsrt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic [6:0] active_slots;
	ctrl_cmd_t  cmd;
	dp_stat_t   stat;

	tsrt_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.active_slots (active_slots)
	);

	tsrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsrt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_in       (req),
		.active_slots (active_slots),
		.cmd          (cmd),
		.stat         (stat),
		.rsp          (rsp),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready)
	);

endmodule
`default_nettype wire

/* rtl/core/tsrt_regs.sv */
// Configuration register block: APB-style access to the active slot count
`default_nettype none
module tsrt_regs
	import tsrt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [6:0]         active_slots
);

	logic [6:0] active_slots_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= '0;
		end else if (wr_en && paddr[PADDR_W-1] == REG_ACTIVE_SLOTS) begin
			active_slots_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_ACTIVE_SLOTS) begin
			prdata = PDATA_W'(active_slots_q);
		end
	end

	assign active_slots = active_slots_q;

endmodule
`default_nettype wire

/* rtl/core/tsrt_ctrl.sv */
// Controller state machine: sequences accept, execute, scan and result delivery
`default_nettype none
module tsrt_ctrl
	import tsrt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.is_init) begin
					cmd.init_wr = 1'b1;
					state_d     = ST_WAIT;
				end else if (stat.is_search) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					cmd.zero_res = 1'b1;
					state_d      = ST_WAIT;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					cmd.capture = 1'b1;
					state_d     = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/tsrt_dp.sv */
// Datapath: slot memory, valid and owner flags, scan pipeline and result registers
`default_nettype none
module tsrt_dp
	import tsrt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_t       req_in,
	input  wire logic [6:0] active_slots,
	input  wire ctrl_cmd_t  cmd,
	output dp_stat_t        stat,
	output rsp_t            rsp,
	output logic            rsp_valid,
	input  wire logic       rsp_ready
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	req_t             req_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] owned_q;
	entry_t           mem [SLOTS];

	logic [CW-1:0]    rd_idx_q;
	logic [CW-1:0]    end_q;
	logic             scan_q;
	logic             pend_s1;
	logic [AW-1:0]    idx_s1;
	entry_t           rd_data_s1;

	logic [7:0]       sel8;
	logic [7:0]       act8;
	logic [7:0]       n8;
	logic             init_ok;
	logic             id_ok;
	logic             more;
	logic             issue;
	logic             cond;
	logic             hit;
	logic             is_reserve;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;
	logic [7:0]       idx8;

	assign sel8       = 8'(req_q.slot_sel);
	assign act8       = 8'(active_slots);
	assign n8         = (act8 > 8'(SLOTS)) ? 8'(SLOTS) : act8;
	assign init_ok    = sel8 < 8'(SLOTS);
	assign id_ok      = sel8 < n8;
	assign is_reserve = req_q.func == FUNC_RESERVE;
	assign more       = rd_idx_q < end_q;
	assign idx8       = 8'(idx_s1);

	always_comb begin
		stat.is_init   = 1'b0;
		stat.is_search = 1'b0;
		case (req_q.func) inside
			FUNC_INIT: stat.is_init = 1'b1;
			FUNC_RESERVE, FUNC_FIND_OWNER, FUNC_FIND_ID, FUNC_FIND_POS:
				stat.is_search = 1'b1;
			default: ;
		endcase
		stat.scan_done = scan_q & (hit | (!pend_s1 & !more));
		stat.out_free  = !rsp_valid_q | rsp_ready;
	end

	always_comb begin
		cond = 1'b0;
		case (req_q.func)
			FUNC_RESERVE:
				cond = !owned_q[idx_s1] && rd_data_s1.kind == req_q.kind;
			FUNC_FIND_OWNER:
				cond = owned_q[idx_s1] && rd_data_s1.kind == req_q.kind &&
					rd_data_s1.owner == req_q.client;
			FUNC_FIND_ID:
				cond = 1'b1;
			FUNC_FIND_POS:
				cond = rd_data_s1.x == req_q.pos_x && rd_data_s1.y == req_q.pos_y;
			default:
				cond = 1'b0;
		endcase
	end

	assign hit   = pend_s1 & valid_q[idx_s1] & cond;
	assign issue = scan_q & more & !hit;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = '{x: rd_data_s1.x, y: rd_data_s1.y, kind: rd_data_s1.kind,
			owner: req_q.client};
		if (cmd.init_wr) begin
			wr_en   = init_ok;
			wr_addr = sel8[AW-1:0];
			wr_data = '{x: req_q.pos_x, y: req_q.pos_y, kind: req_q.kind, owner: 8'd0};
		end else if (cmd.capture) begin
			wr_en = hit & is_reserve;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
			idx_s1     <= rd_idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_in;
		end
		if (cmd.init_wr) begin
			res_q <= '{found: 1'b1, slot: req_q.slot_sel, out_x: req_q.pos_x,
				out_y: req_q.pos_y, out_kind: req_q.kind};
		end else if (cmd.zero_res) begin
			res_q <= '0;
		end else if (cmd.capture) begin
			if (hit) begin
				res_q <= '{found: 1'b1, slot: idx8[5:0], out_x: rd_data_s1.x,
					out_y: rd_data_s1.y, out_kind: rd_data_s1.kind};
			end else begin
				res_q <= '0;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
		if (cmd.scan_start) begin
			if (req_q.func == FUNC_FIND_ID) begin
				rd_idx_q <= id_ok ? sel8[CW-1:0] : '0;
				end_q    <= id_ok ? CW'(sel8 + 8'd1) : '0;
			end else begin
				rd_idx_q <= '0;
				end_q    <= n8[CW-1:0];
			end
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			owned_q     <= '0;
			scan_q      <= 1'b0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr && init_ok) begin
				valid_q[sel8[AW-1:0]] <= 1'b1;
				owned_q[sel8[AW-1:0]] <= 1'b0;
			end else if (cmd.capture && hit && is_reserve) begin
				owned_q[idx_s1] <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_q  <= 1'b1;
				pend_s1 <= 1'b0;
			end else if (cmd.capture) begin
				scan_q  <= 1'b0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire
